// ===== rtl/iocb_pkg.sv =====
`default_nettype none

package iocb_pkg;

    // Fixed widths of the item fields.
    localparam int unsigned RESP_ID_W = 8;
    localparam int unsigned EVENT_W   = 3;
    localparam int unsigned REQ_ID_W  = 8;

    // At most this many entries retire on one response beat.
    localparam int unsigned MAX_RESULTS = 16;
    localparam int unsigned RET_W       = 5;

    // Result event codes.
    localparam logic [EVENT_W-1:0] EV_ISSUED  = 3'd0;
    localparam logic [EVENT_W-1:0] EV_REFUSED = 3'd1;
    localparam logic [EVENT_W-1:0] EV_FULL    = 3'd2;
    localparam logic [EVENT_W-1:0] EV_RETIRED = 3'd3;
    localparam logic [EVENT_W-1:0] EV_UNKNOWN = 3'd4;

    // Input item modes.
    localparam logic MODE_ISSUE    = 1'b0;
    localparam logic MODE_RESPONSE = 1'b1;

    typedef struct packed {
        logic                 mode;
        logic                 is_write;
        logic                 port_accepted;
        logic [RESP_ID_W-1:0] response_id;
    } t_in_item;

    typedef struct packed {
        logic [EVENT_W-1:0]  event_res;
        logic [REQ_ID_W-1:0] request_id;
        logic                was_write;
        logic                last;
    } t_result;

endpackage : iocb_pkg

`default_nettype wire

// ===== rtl/iocb_store.sv =====
`default_nettype none

module iocb_store #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned ID_W  = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [ID_W-1:0]          i_wr_id,
    input  wire logic                     i_wr_write,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [ID_W-1:0]          o_rd_id,
    output logic                          o_rd_write,
    input  wire logic                     i_set_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_set_addr,
    input  wire logic                     i_clr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_clr_addr,
    input  wire logic [$clog2(DEPTH)-1:0] i_chk_a_addr,
    output logic                          o_chk_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_chk_b_addr,
    output logic                          o_chk_b
);

    // Entry memory: write flag above the id, one word per slot.
    logic [ID_W:0]      r_mem [DEPTH];
    logic [ID_W:0]      r_rd_word;
    // Response-seen flags, one flip-flop per slot.
    logic [DEPTH-1:0]   r_matched;

    // Single write port and a registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_write, i_wr_id};
        end
        r_rd_word <= r_mem[i_rd_addr];
    end

    assign o_rd_id    = r_rd_word[ID_W-1:0];
    assign o_rd_write = r_rd_word[ID_W];

    // Flags are set on a match and cleared on retirement or a fresh write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matched <= '0;
        end else begin
            if (i_set_en) begin
                r_matched[i_set_addr] <= 1'b1;
            end
            if (i_clr_en) begin
                r_matched[i_clr_addr] <= 1'b0;
            end
            if (i_wr_en) begin
                r_matched[i_wr_addr] <= 1'b0;
            end
        end
    end

    assign o_chk_a = r_matched[i_chk_a_addr];
    assign o_chk_b = r_matched[i_chk_b_addr];

endmodule : iocb_store

`default_nettype wire

// ===== rtl/in_order_completion_buffer.sv =====
`default_nettype none

// In-order completion buffer.
// An item is offered on i_item with start and taken on the clock edge where
// start is high and busy is low. An issue beat (mode 0) gives the request the
// next wrapping id and appends it to the queue unless the queue is full or the
// port refused it. A response beat (mode 1) marks the oldest unmatched entry
// with that id and then retires matched entries from the head in issue order.
// Every result is shown on o_result for exactly one cycle with o_valid high;
// o_result.last flags the final result of the item. The receiver cannot stall,
// so results are never held back.
// Flow: an issue beat's result is registered and appears in the cycle after
// the beat is taken, and busy stays low, so issues may follow back to back. A
// response walks the queue from the head through the single entry memory read
// port and one id comparator, each entry examined in S_SRD then S_SCMP, then
// retires each entry through S_RRD then S_ROUT; busy is high throughout. An
// unknown id is reported from S_SRD once every entry has been examined. A
// response whose entry is not at the head gives no result and ends in the
// following S_RRD state, once the head is seen unmatched.
// Reset empties the queue, clears all match flags and sets the next id to zero.

module in_order_completion_buffer #(
    parameter int unsigned QUEUE_DEPTH = 16,
    parameter int unsigned ID_BITS     = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire iocb_pkg::t_in_item i_item,
    output logic                   o_valid,
    output iocb_pkg::t_result      o_result
);

    localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned SUM_W = CNT_W + 1;
    localparam int unsigned RET_W = iocb_pkg::RET_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SRD  = 5'b00010,
        S_SCMP = 5'b00100,
        S_RRD  = 5'b01000,
        S_ROUT = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_head, n_head;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [ID_BITS-1:0]  r_next_id, n_next_id;
    logic [ID_BITS-1:0]  r_rid, n_rid;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic [IDX_W-1:0]    r_slot, n_slot;
    logic [RET_W-1:0]    r_nret, n_nret;
    logic                r_valid, n_valid;
    iocb_pkg::t_result   r_out, n_out;

    logic                accept;
    logic [SUM_W-1:0]    tail_sum;
    logic [IDX_W-1:0]    tail_slot;
    logic [IDX_W-1:0]    head_nx;
    logic [IDX_W-1:0]    slot_nx;
    logic [ID_BITS+7:0]  rid_wide;
    logic [ID_BITS+7:0]  next_id_wide;
    logic [ID_BITS+7:0]  rd_id_wide;
    logic [ID_BITS+7:0]  cur_rid_wide;
    logic [RET_W-1:0]    nret_inc;
    logic                more_ret;

    // Store interface.
    logic                st_wr_en;
    logic [IDX_W-1:0]    st_rd_addr;
    logic [ID_BITS-1:0]  st_rd_id;
    logic                st_rd_write;
    logic                st_set_en;
    logic                st_clr_en;
    logic [IDX_W-1:0]    st_chk_a_addr;
    logic                st_chk_a;
    logic                st_chk_b;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);

    // Slot behind the newest entry, wrapped once at most.
    assign tail_sum  = SUM_W'(r_head) + SUM_W'(r_count);
    assign tail_slot = (tail_sum >= SUM_W'(QUEUE_DEPTH))
                     ? IDX_W'(tail_sum - SUM_W'(QUEUE_DEPTH))
                     : IDX_W'(tail_sum);

    assign head_nx = (r_head == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + IDX_W'(1);
    assign slot_nx = (r_slot == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : r_slot + IDX_W'(1);

    // Width adaption between the 8-bit id fields and the internal id width.
    assign rid_wide     = {{ID_BITS{1'b0}}, i_item.response_id};
    assign next_id_wide = {8'd0, r_next_id};
    assign rd_id_wide   = {8'd0, st_rd_id};
    assign cur_rid_wide = {8'd0, r_rid};

    // Whether another retirement follows the one being shown.
    assign nret_inc = r_nret + RET_W'(1);
    assign more_ret = (r_count > CNT_W'(1))
                   && (nret_inc < RET_W'(iocb_pkg::MAX_RESULTS))
                   && st_chk_b;

    assign st_rd_addr    = (r_state == S_RRD) ? r_head : r_slot;
    assign st_chk_a_addr = (r_state == S_SCMP) ? r_slot : r_head;

    // Sequencer: issue in one step, search then drain for a response.
    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_count   = r_count;
        n_next_id = r_next_id;
        n_rid     = r_rid;
        n_idx     = r_idx;
        n_slot    = r_slot;
        n_nret    = r_nret;
        n_valid   = 1'b0;
        n_out     = r_out;
        st_wr_en  = 1'b0;
        st_set_en = 1'b0;
        st_clr_en = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_item.mode == iocb_pkg::MODE_ISSUE) begin
                        n_valid              = 1'b1;
                        n_out.request_id     = next_id_wide[7:0];
                        n_out.was_write      = i_item.is_write;
                        n_out.last           = 1'b1;
                        if (r_count == CNT_W'(QUEUE_DEPTH)) begin
                            n_out.event_res = iocb_pkg::EV_FULL;
                        end else begin
                            n_next_id = r_next_id + ID_BITS'(1);
                            if (!i_item.port_accepted) begin
                                n_out.event_res = iocb_pkg::EV_REFUSED;
                            end else begin
                                n_out.event_res = iocb_pkg::EV_ISSUED;
                                st_wr_en        = 1'b1;
                                n_count         = r_count + CNT_W'(1);
                            end
                        end
                    end else begin
                        n_rid   = rid_wide[ID_BITS-1:0];
                        n_idx   = '0;
                        n_slot  = r_head;
                        n_state = S_SRD;
                    end
                end
            end
            S_SRD: begin
                if (r_idx == r_count) begin
                    n_valid          = 1'b1;
                    n_out.event_res  = iocb_pkg::EV_UNKNOWN;
                    n_out.request_id = cur_rid_wide[7:0];
                    n_out.was_write  = 1'b0;
                    n_out.last       = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    n_state = S_SCMP;
                end
            end
            S_SCMP: begin
                if (!st_chk_a && (st_rd_id == r_rid)) begin
                    st_set_en = 1'b1;
                    n_nret    = '0;
                    n_state   = S_RRD;
                end else begin
                    n_idx   = r_idx + CNT_W'(1);
                    n_slot  = slot_nx;
                    n_state = S_SRD;
                end
            end
            S_RRD: begin
                if ((r_count != '0) && (r_nret < RET_W'(iocb_pkg::MAX_RESULTS))
                    && st_chk_a) begin
                    n_state = S_ROUT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_ROUT: begin
                n_valid          = 1'b1;
                n_out.event_res  = iocb_pkg::EV_RETIRED;
                n_out.request_id = rd_id_wide[7:0];
                n_out.was_write  = st_rd_write;
                n_out.last       = !more_ret;
                st_clr_en        = 1'b1;
                n_head           = head_nx;
                n_count          = r_count - CNT_W'(1);
                n_nret           = nret_inc;
                n_state          = more_ret ? S_RRD : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_count   <= '0;
            r_next_id <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_count   <= n_count;
            r_next_id <= n_next_id;
            r_valid   <= n_valid;
        end
    end

    // Working and result payload registers.
    always_ff @(posedge i_clk) begin
        r_rid  <= n_rid;
        r_idx  <= n_idx;
        r_slot <= n_slot;
        r_nret <= n_nret;
        r_out  <= n_out;
    end

    assign o_valid  = r_valid;
    assign o_result = r_out;

    iocb_store #(
        .DEPTH (QUEUE_DEPTH),
        .ID_W  (ID_BITS)
    ) u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr_en      (st_wr_en),
        .i_wr_addr    (tail_slot),
        .i_wr_id      (r_next_id),
        .i_wr_write   (i_item.is_write),
        .i_rd_addr    (st_rd_addr),
        .o_rd_id      (st_rd_id),
        .o_rd_write   (st_rd_write),
        .i_set_en     (st_set_en),
        .i_set_addr   (r_slot),
        .i_clr_en     (st_clr_en),
        .i_clr_addr   (r_head),
        .i_chk_a_addr (st_chk_a_addr),
        .o_chk_a      (st_chk_a),
        .i_chk_b_addr (head_nx),
        .o_chk_b      (st_chk_b)
    );

    // The queue never holds more entries than it has slots.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count exceeds queue depth");

    // An accepted beat either starts a search or gives its result at once.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (busy || o_valid))
        else $error("accepted beat neither busy nor answered");

    // Only retirements may be followed by further results of the same beat.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.last) |-> (busy && (o_result.event_res == iocb_pkg::EV_RETIRED)))
        else $error("non-final result that is not a retirement");

    // Every retirement removes exactly one entry.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUT) |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("retirement did not shrink the queue by one");

endmodule : in_order_completion_buffer

`default_nettype wire

// ===== tb/sv/tb.sv =====
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned QUEUE_DEPTH = 16;
    localparam int unsigned ID_BITS     = 8;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned PHASE_ITEMS = 60;

    // Tracks the buffer's queue, works out the results of every accepted beat and
    // checks what the block returns against them in order.
    class completion_scoreboard;
        logic [ID_BITS-1:0] slot_id [QUEUE_DEPTH];
        bit                 slot_write [QUEUE_DEPTH];
        bit                 slot_matched [QUEUE_DEPTH];
        int unsigned        head_slot;
        int unsigned        held;
        logic [ID_BITS-1:0] next_id;
        iocb_pkg::t_result  awaited [$];
        int unsigned        mismatches;
        int unsigned        items;
        int unsigned        results;
        int unsigned        retired;
        int unsigned        deepest_drain;
        int unsigned        full_hits;
        int unsigned        unknown_hits;
        int unsigned        shared_matches;

        function new();
            head_slot = 0;
            held      = 0;
            next_id   = '0;
            foreach (slot_matched[i]) slot_matched[i] = 1'b0;
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= 40) $display("MISMATCH at %0t ns: %s", $time, what);
        endtask

        function void push_expected(logic [iocb_pkg::EVENT_W-1:0] ev,
                                    logic [iocb_pkg::REQ_ID_W-1:0] id,
                                    logic wr, logic lst);
            iocb_pkg::t_result r;
            r.event_res  = ev;
            r.request_id = id;
            r.was_write  = wr;
            r.last       = lst;
            awaited = {awaited, r};
        endfunction

        // Predicts the results of one accepted beat and updates the queue copy.
        function void note_item(iocb_pkg::t_in_item it);
            logic [ID_BITS-1:0] id;
            int unsigned        s;
            int unsigned        i;
            int unsigned        drain;
            int unsigned        sharing;
            bit                 found;
            items++;
            if (it.mode == iocb_pkg::MODE_ISSUE) begin
                id = next_id;
                if (held == QUEUE_DEPTH) begin
                    // A full queue refuses without using an id.
                    full_hits++;
                    push_expected(iocb_pkg::EV_FULL, id, it.is_write, 1'b1);
                end else begin
                    next_id = id + 1'b1;
                    if (!it.port_accepted) begin
                        push_expected(iocb_pkg::EV_REFUSED, id, it.is_write, 1'b1);
                    end else begin
                        s = (head_slot + held) % QUEUE_DEPTH;
                        slot_id[s]      = id;
                        slot_write[s]   = it.is_write;
                        slot_matched[s] = 1'b0;
                        held++;
                        push_expected(iocb_pkg::EV_ISSUED, id, it.is_write, 1'b1);
                    end
                end
                return;
            end

            // The oldest unmatched entry with this id takes the response.
            id      = it.response_id[ID_BITS-1:0];
            found   = 1'b0;
            sharing = 0;
            for (i = 0; i < held; i++) begin
                s = (head_slot + i) % QUEUE_DEPTH;
                if (slot_id[s] == id) sharing++;
                if (!found && !slot_matched[s] && slot_id[s] == id) begin
                    slot_matched[s] = 1'b1;
                    found           = 1'b1;
                end
            end
            if (!found) begin
                unknown_hits++;
                push_expected(iocb_pkg::EV_UNKNOWN, id, 1'b0, 1'b1);
                return;
            end
            if (sharing > 1) shared_matches++;

            // Matched entries leave from the head in issue order.
            drain = 0;
            while (drain < held && drain < iocb_pkg::MAX_RESULTS &&
                   slot_matched[(head_slot + drain) % QUEUE_DEPTH]) drain++;
            for (i = 0; i < drain; i++) begin
                push_expected(iocb_pkg::EV_RETIRED, slot_id[head_slot],
                              slot_write[head_slot], i == drain - 1);
                slot_matched[head_slot] = 1'b0;
                head_slot = (head_slot + 1) % QUEUE_DEPTH;
                held--;
            end
            retired += drain;
            if (drain > deepest_drain) deepest_drain = drain;
        endfunction

        // Compares one result beat with the oldest outstanding expectation.
        task check_result(iocb_pkg::t_result got);
            iocb_pkg::t_result want;
            results++;
            if (awaited.size() == 0) begin
                report($sformatf("result with nothing expected: event %0d id %0d",
                                 got.event_res, got.request_id));
                return;
            end
            want = awaited[0];
            awaited.delete(0);
            if (got.event_res !== want.event_res)
                report($sformatf("event_res %0d, expected %0d (id %0d)",
                                 got.event_res, want.event_res, want.request_id));
            if (got.request_id !== want.request_id)
                report($sformatf("request_id %0d, expected %0d", got.request_id,
                                 want.request_id));
            if (got.was_write !== want.was_write)
                report($sformatf("was_write %0b, expected %0b (id %0d)", got.was_write,
                                 want.was_write, want.request_id));
            if (got.last !== want.last)
                report($sformatf("last %0b, expected %0b (id %0d)", got.last, want.last,
                                 want.request_id));
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               start   = 1'b0;
    logic               busy;
    iocb_pkg::t_in_item i_item  = '0;
    logic               o_valid;
    iocb_pkg::t_result  o_result;

    completion_scoreboard sb;
    int unsigned idle_pct = 0;
    int unsigned cycles   = 0;

    in_order_completion_buffer #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .ID_BITS    (ID_BITS)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result beats are taken on the edge that ends their cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) sb.check_result(o_result);
    end

    // Guard against a hung block.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding", cycles,
                     sb.awaited.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic iocb_pkg::t_in_item issue_item(bit accepted);
        iocb_pkg::t_in_item it;
        it.mode          = iocb_pkg::MODE_ISSUE;
        it.is_write      = 1'($urandom_range(1));
        it.port_accepted = accepted;
        it.response_id   = iocb_pkg::RESP_ID_W'($urandom_range(255));
        return it;
    endfunction

    function automatic iocb_pkg::t_in_item response_item(
        logic [iocb_pkg::RESP_ID_W-1:0] id);
        iocb_pkg::t_in_item it;
        it.mode          = iocb_pkg::MODE_RESPONSE;
        it.is_write      = 1'($urandom_range(1));
        it.port_accepted = 1'($urandom_range(1));
        it.response_id   = id;
        return it;
    endfunction

    // Id of an unmatched held entry, leaning towards the head so that drains happen.
    function automatic logic [iocb_pkg::RESP_ID_W-1:0] outstanding_id();
        int unsigned open_slots [$];
        int unsigned s;
        for (int unsigned i = 0; i < sb.held; i++) begin
            s = (sb.head_slot + i) % QUEUE_DEPTH;
            if (!sb.slot_matched[s]) open_slots = {open_slots, s};
        end
        if ($urandom_range(99) < 35) return sb.slot_id[open_slots[0]];
        return sb.slot_id[open_slots[$urandom_range(open_slots.size() - 1)]];
    endfunction

    // Mostly well-formed traffic: issues and responses to held ids, with some noise.
    function automatic iocb_pkg::t_in_item random_item(int unsigned issue_pct);
        int unsigned r;
        r = $urandom_range(99);
        if (r < issue_pct) return issue_item($urandom_range(99) < 85);
        if (r < 95 && sb.held > 0) return response_item(outstanding_id());
        return response_item(iocb_pkg::RESP_ID_W'($urandom_range(255)));
    endfunction

    // Offers one beat after a random gap and waits until the block takes it.
    task automatic send_item(iocb_pkg::t_in_item it);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_item(it);
    endtask

    initial begin
        iocb_pkg::t_in_item it;
        int unsigned        k;
        int unsigned        phase;
        int unsigned        issue_pct;
        logic [ID_BITS-1:0] target;

        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed beats: empty-queue responses, refusals, a full queue, a response
        // behind an unmatched head, a repeated response and a head retirement.
        idle_pct = 30;
        send_item(response_item(8'h00));
        send_item(response_item(8'hFF));
        it = issue_item(1'b0);
        it.is_write = 1'b1;
        send_item(it);
        it.is_write = 1'b0;
        send_item(it);
        for (k = 0; k < QUEUE_DEPTH; k++) begin
            it = issue_item(1'b1);
            it.is_write = 1'(k % 2);
            send_item(it);
        end
        it = issue_item(1'b1);
        it.is_write = 1'b1;
        send_item(it);
        it = issue_item(1'b0);
        it.is_write = 1'b0;
        send_item(it);
        send_item(response_item(8'd17));
        send_item(response_item(8'd17));
        send_item(response_item(8'd2));

        // Random phases with differing sender gaps and issue mixes.
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  issue_pct = 50; end
                1: begin idle_pct = 69; issue_pct = 60; end
                2: begin idle_pct = 0;  issue_pct = 45; end
                default: begin idle_pct = 19; issue_pct = 55; end
            endcase
            if (phase == 1) begin
                // Wrap the id counter round a held entry with refused issues, so that
                // new entries share ids with old ones.
                while (sb.held < 4 || sb.held == QUEUE_DEPTH)
                    send_item(sb.held < 4 ? issue_item(1'b1)
                                          : response_item(sb.slot_id[sb.head_slot]));
                target = sb.slot_id[sb.head_slot];
                while (sb.next_id != target - 8'd2) send_item(issue_item(1'b0));
                repeat (6) send_item(issue_item(1'b1));
            end
            repeat (PHASE_ITEMS) send_item(random_item(issue_pct));
        end

        // Drain: wait for every expected beat and for the block to go quiet.
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.awaited.size() != 0 || busy) @(posedge i_clk);
        repeat (64) @(posedge i_clk);

        $display("Covered %0d beats in, %0d results out, %0d retirements (up to %0d at once).",
                 sb.items, sb.results, sb.retired, sb.deepest_drain);
        $display("Full-queue issues %0d, unknown-id responses %0d, matches on shared ids %0d.",
                 sb.full_hits, sb.unknown_hits, sb.shared_matches);
        if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
